// ===== rtl/hcp_pkg.sv =====
// shared constants and the hex digit function for the hex cookie generator
package hcp_pkg;

    localparam int unsigned COOKIE_LEN = 16;

    localparam logic [31:0] ADD_CONST = 32'hdeadbeef;
    localparam logic [31:0] SUB_CONST = 32'hcafebabe;

    // rounds per run are 32 plus the low five time bits
    localparam logic [5:0] ROUND_BASE = 6'd32;

    function automatic logic [6:0] hex_digit(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10) begin
            c = 7'h30 + {3'b000, nib};
        end else begin
            c = 7'h57 + {3'b000, nib};
        end
        return c;
    endfunction

endpackage

// ===== rtl/hex_cookie_prng_unit.sv =====
// hex cookie generator: sequencer, shared shift/add/rotate datapath and output register
//
//  channel | direction | signals                       | beat
//  --------+-----------+-------------------------------+-------------------------------
//  in      | input     | i_in_valid, o_in_stall        | one 64-bit time value
//  out     | output    | o_out_valid, i_out_stall      | one hex character + last flag
//  cfg     | input     | i_cfg_we, i_cfg_data          | seed load, no back-pressure
//
// one request runs ceil(COOKIE_LEN/4) generator runs; a run is 32 + now_ms[4:0] rounds
// and each round passes phase by phase through the shared shift/add/rotate unit; each
// character then passes through the output register. the input is stalled from acceptance
// until the last character is loaded. reset is synchronous, active low, and clears the
// seed to zero; a stalled output holds its character while the next one waits in the
// sequencer.
module hex_cookie_prng_unit
    import hcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_now_ms,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [6:0]  o_hex_char,
    output logic        o_last_char
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } t_state;

    t_state      r_state;
    logic [63:0] r_now;
    logic [63:0] r_work;
    logic [31:0] r_seed;
    logic [5:0]  r_round;
    logic [1:0]  r_phase;
    logic [6:0]  r_char_index;
    logic [15:0] r_val;
    logic        r_out_valid;
    logic [6:0]  r_hex_char;
    logic        r_last_char;

    // datapath results for the current phase
    logic [63:0] n_work;
    logic [31:0] n_seed;

    // shared unit signals
    logic [4:0]  w_wide_amt;
    logic [5:0]  w_wide_left;
    logic [63:0] w_wide;
    logic [31:0] w_add_opd;
    logic        w_add_sub;
    logic [31:0] w_sum;
    logic [4:0]  w_rot_amt;
    logic [63:0] w_rot_pair;
    logic [31:0] w_rot;
    logic        w_last_round;
    logic        w_last_char;
    logic        w_out_free;
    logic        w_in_take;

    assign w_in_take  = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_last_char  = (r_char_index == 7'(COOKIE_LEN - 1));
    assign w_last_round = (r_phase == 2'd3)
                       && (r_round == ({1'b0, r_now[4:0]} + ROUND_BASE - 6'd1));

    always_comb begin
        // 64-bit step keeps the c shift expression: right by r, left by 32 - r
        w_wide_amt  = r_phase[1] ? r_seed[16:12] : r_seed[4:0];
        w_wide_left = 6'd32 - {1'b0, w_wide_amt};
        w_wide      = (r_work >> w_wide_amt) | (r_work << w_wide_left);

        // adder: data add/sub in the first half, constant add/sub in the second
        if (r_phase[1]) begin
            w_add_opd = w_wide[2] ? ADD_CONST : SUB_CONST;
            w_add_sub = !w_wide[2];
        end else begin
            w_add_opd = w_wide[31:0];
            w_add_sub = !w_wide[0];
        end
        w_sum = w_add_sub ? (r_seed - w_add_opd) : (r_seed + w_add_opd);

        // 32-bit right rotate, zero amount falls out as no rotation
        w_rot_amt  = r_phase[1] ? r_work[20:16] : r_work[10:6];
        w_rot_pair = {r_seed, r_seed} >> w_rot_amt;
        w_rot      = w_rot_pair[31:0];

        n_work = r_work;
        n_seed = r_seed;
        case (r_phase)
            2'd0, 2'd2: begin
                n_work = w_wide;
                n_seed = w_sum;
            end
            2'd1: begin
                if (w_rot[1]) begin
                    n_seed = w_rot ^ r_work[31:0];
                end else begin
                    n_seed = w_rot;
                    n_work = r_work ^ {32'h0, w_rot};
                end
            end
            default: begin
                if (r_work[3]) begin
                    n_seed = w_rot;
                    n_work = r_work ^ {32'h0, w_rot};
                end else begin
                    n_seed = w_rot ^ r_work[31:0];
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_seed       <= 32'h0;
            r_work       <= 64'h0;
            r_round      <= 6'd0;
            r_phase      <= 2'd0;
            r_char_index <= 7'd0;
            r_out_valid  <= 1'b0;
        end else begin
            // a taken beat empties the register unless a new character replaces it
            if (r_out_valid && !i_out_stall && (r_state != ST_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    // seed load, only written while idle
                    if (i_cfg_we) begin
                        r_seed <= i_cfg_data;
                    end
                    if (w_in_take) begin
                        r_now        <= i_now_ms;
                        r_work       <= i_now_ms;
                        r_round      <= 6'd0;
                        r_phase      <= 2'd0;
                        r_char_index <= 7'd0;
                        r_state      <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    r_work  <= n_work;
                    r_seed  <= n_seed;
                    r_phase <= r_phase + 2'd1;
                    if (r_phase == 2'd3) begin
                        r_round <= r_round + 6'd1;
                    end
                    if (w_last_round) begin
                        r_val   <= n_work[15:0];
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_hex_char   <= hex_digit(r_val[3:0]);
                        r_last_char  <= w_last_char;
                        r_val        <= r_val >> 4;
                        r_char_index <= r_char_index + 7'd1;
                        if (w_last_char) begin
                            r_state <= ST_IDLE;
                        end else if (r_char_index[1:0] == 2'd3) begin
                            // next group of four: fresh run from the same time value
                            r_work  <= r_now;
                            r_round <= 6'd0;
                            r_phase <= 2'd0;
                            r_state <= ST_RUN;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_hex_char  = r_hex_char;
    assign o_last_char = r_last_char;

`ifndef SYNTH
    // every character shown is a lower-case hex digit
    a_hex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_hex_char >= 7'h30 && o_hex_char <= 7'h39)
                      || (o_hex_char >= 7'h61 && o_hex_char <= 7'h66)))
        else $error("cookie character out of hex range");

    // round phase only advances while a run is active
    a_phase_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_RUN) |-> (r_phase == 2'd0))
        else $error("round phase left nonzero outside a run");

    // character index never passes the cookie length
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_char_index < 7'(COOKIE_LEN)))
        else $error("character index past cookie length");

    // the last flag sends the sequencer back to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && w_out_free && w_last_char) |=> (r_state == ST_IDLE))
        else $error("sequencer busy after the last character");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the hex cookie generator: queued driver, checking monitor, cookie predictor
`timescale 1ns / 100ps

module testbench;
    import hcp_pkg::*;

    // one expected character of a cookie
    typedef struct packed {
        logic [6:0] hex;
        logic       last;
    } t_cookie_char;

    localparam logic [6:0] DIGIT_ZERO = 7'h30;  // ascii '0'
    localparam logic [6:0] LETTER_A   = 7'h61;  // ascii 'a'

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic [63:0] i_now_ms    = '0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [6:0]  o_hex_char;
    logic        o_last_char;

    // request times not yet presented to the block
    logic [63:0]  pending_times[$];
    // characters predicted for accepted requests, oldest first
    t_cookie_char cookie_chars[$];

    // predictor copy of the generator seed, follows every seed write
    logic [31:0] gen_seed = '0;

    int  send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
    int  stall_pct     = 0;   // chance in a hundred that the receiver stalls a cycle
    int  mismatches    = 0;
    logic in_taken     = 1'b0;  // the presented request beat went in at the last edge

    hex_cookie_prng_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_now_ms    (i_now_ms),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_hex_char  (o_hex_char),
        .o_last_char (o_last_char)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // 64-bit step: right shift by r or'ed with a left shift by 32 - r, nothing wraps
    // around, so a zero amount gives w | (w << 32)
    function automatic logic [63:0] wide_spin(input logic [63:0] v, input logic [4:0] r);
        logic [5:0] back;
        back = 6'd32 - {1'b0, r};
        return (v >> r) | (v << back);
    endfunction

    // true 32-bit right rotate, zero amount leaves the value alone
    function automatic logic [31:0] spin32(input logic [31:0] v, input logic [4:0] r);
        logic [5:0] back;
        back = 6'd32 - {1'b0, r};
        if (r == 5'd0) begin
            return v;
        end
        return (v >> r) | (v << back);
    endfunction

    // one generator run: 32 + now[4:0] rounds against the persistent seed
    task automatic run_mixer(input logic [63:0] now, output logic [31:0] mixed);
        logic [63:0] w;
        int          rounds;
        w      = now;
        rounds = 32 + int'(now[4:0]);
        for (int k = 0; k < rounds; k++) begin
            w = wide_spin(w, gen_seed[4:0]);
            if (w[0]) begin
                gen_seed = gen_seed + w[31:0];
            end else begin
                gen_seed = gen_seed - w[31:0];
            end
            gen_seed = spin32(gen_seed, w[10:6]);
            // seed bit 1 picks which side absorbs the other
            if (gen_seed[1]) begin
                gen_seed = gen_seed ^ w[31:0];
            end else begin
                w = w ^ {32'h0, gen_seed};
            end
            w = wide_spin(w, gen_seed[16:12]);
            if (w[2]) begin
                gen_seed = gen_seed + ADD_CONST;
            end else begin
                gen_seed = gen_seed - SUB_CONST;
            end
            gen_seed = spin32(gen_seed, w[20:16]);
            if (w[3]) begin
                w = w ^ {32'h0, gen_seed};
            end else begin
                gen_seed = gen_seed ^ w[31:0];
            end
        end
        mixed = w[31:0];
    endtask

    // queue the whole cookie for one accepted request
    task automatic predict_cookie(input logic [63:0] now);
        logic [31:0]  nibbles;
        logic [3:0]   nib;
        t_cookie_char c;
        nibbles = '0;
        for (int i = 0; i < int'(COOKIE_LEN); i++) begin
            // a fresh run feeds every group of four characters, low nibble first
            if (i % 4 == 0) begin
                run_mixer(now, nibbles);
            end
            nib    = nibbles[3:0];
            c.hex  = (nib < 4'd10) ? DIGIT_ZERO + 7'(nib) : LETTER_A + 7'(nib) - 7'd10;
            c.last = (i == int'(COOKIE_LEN) - 1);
            cookie_chars.push_back(c);
            nibbles = nibbles >> 4;
        end
    endtask

    // ------------------------------------------------------------------
    // driver: request beats from the pending queue, random receiver stalls
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            // a beat that was not taken stays put, valid and payload unchanged
            if (!i_in_valid || in_taken) begin
                if (pending_times.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_now_ms   <= pending_times.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // monitor: check characters, then predict for a request taken at this edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cookie_char want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (cookie_chars.size() == 0) begin
                    $display("%0t: character beat with nothing expected, got hex %h last %b",
                             $time, o_hex_char, o_last_char);
                    mismatches++;
                end else begin
                    want = cookie_chars.pop_front();
                    if (o_hex_char !== want.hex) begin
                        $display("%0t: hex_char mismatch, expected %h got %h",
                                 $time, want.hex, o_hex_char);
                        mismatches++;
                    end
                    if (o_last_char !== want.last) begin
                        $display("%0t: last_char mismatch, expected %b got %b",
                                 $time, want.last, o_last_char);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predict_cookie(i_now_ms);
            end
            in_taken <= i_in_valid && !o_in_stall;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // nothing queued, nothing on the wire, every character back
    function automatic bit all_drained();
        return pending_times.size() == 0 && !i_in_valid && cookie_chars.size() == 0;
    endfunction

    // checked a little after the falling edge, once the driver's updates have landed
    task automatic wait_drained();
        do begin
            @(negedge i_clk);
            #1;
        end while (!all_drained());
    endtask

    // seed load while the block sits idle; the predictor follows at once
    task automatic load_seed(input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        gen_seed    = value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // random time: full width, small values, and both ends of the round count
    function automatic logic [63:0] pick_time();
        logic [63:0] t;
        t = {$urandom, $urandom};
        case ($urandom_range(3))
            0: t[63:32] = '0;
            1: t[4:0]   = 5'h1f;
            2: t[4:0]   = 5'h00;
            default: ;
        endcase
        return t;
    endfunction

    task automatic random_phase(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int n = 0; n < count; n++) begin
            pending_times.push_back(pick_time());
        end
        wait_drained();
    endtask

    logic [63:0] directed_times[$] = '{
        64'h0000_0000_0000_0000,   // zero time, fewest rounds
        64'hffff_ffff_ffff_ffff,   // all ones, most rounds
        64'h0000_0000_0000_001f,
        64'h0000_0000_0000_0020,
        64'h8000_0000_0000_0000,
        64'h0000_0000_ffff_ffff,
        64'hffff_ffff_0000_0000,
        64'haaaa_aaaa_aaaa_aaaa,
        64'h5555_5555_5555_5555,
        64'h0000_0001_0000_0001,
        64'h7fff_ffff_ffff_ffe0,
        64'h0123_4567_89ab_cdef,
        64'hfedc_ba98_7654_3210,
        64'h0000_0000_0000_0001
    };

    initial begin
        // reset held low at the start, released on a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: one request at a time, the sender holds off until the
        // whole cookie is back, so every request starts from an idle block
        load_seed(32'h0000_0000);
        foreach (directed_times[j]) begin
            pending_times.push_back(directed_times[j]);
            wait_drained();
        end
        // same time twice in a row shows the seed carrying over
        pending_times.push_back(64'h0000_0000_0000_0010);
        pending_times.push_back(64'h0000_0000_0000_0010);
        wait_drained();

        // random part across seed settings and idling mixes
        load_seed(32'hffff_ffff);
        random_phase(38, 0, 0);
        load_seed($urandom);
        random_phase(39, 64, 0);
        load_seed(32'h8000_0000);
        random_phase(39, 0, 64);
        load_seed($urandom);
        random_phase(38, 34, 34);

        // settle time for any stray beat after the last character
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && cookie_chars.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== hex_cookie_prng_unit.f =====
rtl/hcp_pkg.sv
rtl/hex_cookie_prng_unit.sv
tb/sv/testbench.sv
